// File: design/ibmi_pkg.sv
// shared types, constants and helpers for the indirect block map index core
package ibmi_pkg;

  localparam int unsigned BLK_W = 32;
  localparam int unsigned IDX_W = 14;
  localparam int unsigned LG_W  = 4;

  localparam logic [LG_W-1:0]  LOG2_MIN  = 4'd8;
  localparam logic [LG_W-1:0]  LOG2_MAX  = 4'd14;
  localparam logic [LG_W-1:0]  LOG2_RST  = 4'd8;
  localparam logic [BLK_W-1:0] DIRECT_SLOTS = 32'd12;

  // tree levels
  localparam logic [1:0] LVL_DIRECT = 2'd0;
  localparam logic [1:0] LVL_SINGLE = 2'd1;
  localparam logic [1:0] LVL_DOUBLE = 2'd2;
  localparam logic [1:0] LVL_TRIPLE = 2'd3;

  // inode pointer slots of the indirect roots
  localparam logic [3:0] SLOT_SINGLE = 4'd12;
  localparam logic [3:0] SLOT_DOUBLE = 4'd13;
  localparam logic [3:0] SLOT_TRIPLE = 4'd14;

  // per-block geometry, derived once when the register is written
  typedef struct packed {
    logic [LG_W-1:0]  lg;      // saturated log2 of pointers per block
    logic [BLK_W-1:0] dbl_base; // first block number reached via double indirect
    logic [BLK_W-1:0] tpl_base; // first block number reached via triple indirect
  } ibmi_geom_t;

  // one mapped result
  typedef struct packed {
    logic [1:0]       level;
    logic [3:0]       slot;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;
    logic [IDX_W-1:0] idx3;
    logic             oor;
  } ibmi_res_t;

  // clamp the written value into the legal range
  function automatic logic [LG_W-1:0] sat_log2(input logic [LG_W-1:0] v);
    logic [LG_W-1:0] s;
    s = v;
    if (v < LOG2_MIN) s = LOG2_MIN;
    if (v > LOG2_MAX) s = LOG2_MAX;
    return s;
  endfunction

  // geometry for a given raw register value
  function automatic ibmi_geom_t make_geom(input logic [LG_W-1:0] v);
    ibmi_geom_t g;
    logic [BLK_W-1:0] per;
    logic [BLK_W-1:0] per2;
    g.lg  = sat_log2(v);
    per   = BLK_W'(1) << g.lg;
    per2  = BLK_W'(1) << {g.lg, 1'b0};
    g.dbl_base = DIRECT_SLOTS + per;
    g.tpl_base = DIRECT_SLOTS + per + per2;
    return g;
  endfunction

endpackage

// File: design/indirect_block_map_index_core.sv
// top level: config register, input register, mapping logic and result register
//
// Maps a logical file block number onto the ext2-style inode pointer tree
// (twelve direct slots, then single, double and triple indirect). An item
// taken on in_* is held in the input register, then moves on into the
// result register and is shown on out_* until taken there. One item can
// be taken every cycle while out_tready does not hold a result back: an
// input register and a result register bracket the mapping logic, which
// is one set of parallel subtracts, compares and shifts. The per-block
// geometry is derived when cfg_wr_en writes the register, so the register
// must only be written while no item is in flight. out_tuser carries the
// out-of-range flag for block numbers past the triple-indirect reach.
module indirect_block_map_index_core import ibmi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // ptrs_per_block_log2
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] logical_block
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [1:0] level, [5:2] pointer_slot,
                                     // [19:6] first_index, [33:20] second_index,
                                     // [47:34] third_index
  output logic [0:0]  out_tuser      // [0] out_of_range
);

  ibmi_geom_t       geom_r;
  logic             in_valid_r;
  logic [BLK_W-1:0] blk_r;
  logic             out_valid_r;
  ibmi_res_t        res_r;
  ibmi_res_t        res_nxt;
  logic             out_adv;

  // geometry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= make_geom(LOG2_RST);
    end else if (cfg_wr_en) begin
      geom_r <= make_geom(cfg_wr_data);
    end
  end

  // handshake: each stage loads when it is empty or its item moves on
  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      blk_r <= in_tdata;
    end
  end

  // mapping logic
  ibmi_calc u_calc (
    .blk  (blk_r),
    .geom (geom_r),
    .res  (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.idx3, res_r.idx2, res_r.idx1, res_r.slot, res_r.level};
  assign out_tuser  = res_r.oor;

`ifndef SYNTHESIS
  // an item in the input register moves into a free result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_adv) |=> out_valid_r)
    else $error("input register item not moved to result register");

  // out of range only in the triple region with zeroed indexes
  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.oor) |->
      (res_r.level == LVL_TRIPLE && res_r.slot == SLOT_TRIPLE &&
       res_r.idx1 == '0 && res_r.idx2 == '0 && res_r.idx3 == '0))
    else $error("out-of-range result with wrong level, slot or indexes");

  // register write lands saturated
  a_cfg_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (geom_r.lg >= LOG2_MIN && geom_r.lg <= LOG2_MAX))
    else $error("pointers-per-block log2 outside legal range");

  // a held result keeps its payload until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(res_r))
    else $error("stalled result changed");
`endif

endmodule

// File: design/ibmi_calc.sv
// combinational classification of one block number into tree level and table indexes
module ibmi_calc import ibmi_pkg::*; (
  input  logic [BLK_W-1:0] blk,
  input  ibmi_geom_t       geom,
  output ibmi_res_t        res
);

  logic [BLK_W-1:0] mask;
  logic [BLK_W-1:0] r_sgl;
  logic [BLK_W-1:0] r_dbl;
  logic [BLK_W-1:0] r_tpl;
  logic [BLK_W-1:0] dbl_hi;
  logic [BLK_W-1:0] dbl_lo;
  logic [BLK_W-1:0] tpl_top;
  logic [BLK_W-1:0] tpl_over;
  logic [BLK_W-1:0] tpl_mid;
  logic [BLK_W-1:0] tpl_lo;

  // offsets from the start of each region, in parallel
  assign mask  = (BLK_W'(1) << geom.lg) - BLK_W'(1);
  assign r_sgl = blk - DIRECT_SLOTS;
  assign r_dbl = blk - geom.dbl_base;
  assign r_tpl = blk - geom.tpl_base;

  // digit split inside the double and triple regions
  assign dbl_hi   = r_dbl >> geom.lg;
  assign dbl_lo   = r_dbl & mask;
  assign tpl_top  = r_tpl >> {geom.lg, 1'b0};
  assign tpl_over = tpl_top >> geom.lg;
  assign tpl_mid  = (r_tpl >> geom.lg) & mask;
  assign tpl_lo   = r_tpl & mask;

  // region select
  always_comb begin
    res = '0;
    priority if (blk < DIRECT_SLOTS) begin
      res.level = LVL_DIRECT;
      res.slot  = blk[3:0];
    end else if (blk < geom.dbl_base) begin
      res.level = LVL_SINGLE;
      res.slot  = SLOT_SINGLE;
      res.idx1  = r_sgl[IDX_W-1:0];
    end else if (blk < geom.tpl_base) begin
      res.level = LVL_DOUBLE;
      res.slot  = SLOT_DOUBLE;
      res.idx1  = dbl_hi[IDX_W-1:0];
      res.idx2  = dbl_lo[IDX_W-1:0];
    end else begin
      res.level = LVL_TRIPLE;
      res.slot  = SLOT_TRIPLE;
      if (tpl_over != '0) begin
        res.oor = 1'b1;
      end else begin
        res.idx1 = tpl_top[IDX_W-1:0];
        res.idx2 = tpl_mid[IDX_W-1:0];
        res.idx3 = tpl_lo[IDX_W-1:0];
      end
    end
  end

endmodule
